/* design/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet during reset
`define CHK_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication, quiet during reset
`define CHK_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

/* design/bbam_pkg.sv */
// shared types and codes for the block buffer admission manager
package bbam_pkg;
  localparam int SLOTS = 64;
  localparam int CmdW = 2;
  localparam int LenW = 24;
  localparam int TimeW = 64;
  localparam int IdxW = 6;
  localparam int StatW = 4;
  localparam int LvlW = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_ADMIT = 2'd0, CMD_POP = 2'd1, CMD_RELEASE = 2'd2, CMD_STOP = 2'd3
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_ADMITTED = 4'd0, ST_STOPPED = 4'd1, ST_MALFORMED = 4'd2, ST_SHORT = 4'd3,
    ST_OVERSIZED = 4'd4, ST_POOL_EMPTY = 4'd5, ST_FIFO_FULL = 4'd6, ST_POPPED = 4'd7,
    ST_EMPTY = 4'd8, ST_RELEASED = 4'd9, ST_STOP_DONE = 4'd10
  } status_t;

  localparam logic CFG_BLOCK_BYTES = 1'b0;
  localparam logic CFG_DEPTH_LIMIT = 1'b1;

  // classified command, passed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [LenW-1:0]   len;
    logic [TimeW-1:0]  tbits;
    logic [IdxW-1:0]   rel;
    logic              rel_ok;
    logic              form_ok;
    logic              len_short;
    logic              len_over;
  } job_t;

  typedef struct packed {
    status_t           status;
    logic [IdxW-1:0]   slot;
    logic [63:0]       seq;
    logic [63:0]       first;
    logic [TimeW-1:0]  tout;
    logic              gap;
    logic [LvlW-1:0]   fifo_level;
    logic [LvlW-1:0]   slots_busy;
    logic [LvlW-1:0]   fifo_peak;
    logic [LvlW-1:0]   slots_peak;
    logic [63:0]       lost_bytes;
    logic [63:0]       loss_count;
  } result_t;
endpackage

/* design/bbam_front.sv */
// front: takes command beats, classifies admits against block_bytes
module bbam_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  bbam_pkg::cmd_t            cmd,
  input  logic [bbam_pkg::LenW-1:0] len,
  input  logic [63:0]               tbits,
  input  logic [5:0]                rel,
  input  logic [23:0]               block_bytes,
  output logic                      job_valid,
  input  logic                      job_ready,
  output bbam_pkg::job_t            job
);
  import bbam_pkg::*;
  logic full;
  assign in_ready = !full || job_ready;
  assign job_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (job_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job.cmd <= cmd;
      job.len <= len;
      job.tbits <= tbits;
      job.rel <= rel;
      job.rel_ok <= ({26'd0, rel} < 32'(SLOTS));
      job.form_ok <= (len != '0) && !len[0] && (tbits != '0) && !tbits[63];
      job.len_short <= len < block_bytes;
      job.len_over <= len > block_bytes;
    end
  end
endmodule

/* design/bbam_back.sv */
// back: free stack, ready ring, slot metadata and counters
module bbam_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  bbam_pkg::job_t     job,
  input  logic [6:0]         depth_limit,
  output logic               res_valid,
  input  logic               res_ready,
  output bbam_pkg::result_t  res
);
  import bbam_pkg::*;
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SLOT, S_META} phase_t;

  logic [IdxW-1:0] free_stack [SLOTS];
  logic [IdxW-1:0] ready_fifo [SLOTS];
  logic [63:0]     slot_sequence [SLOTS];
  logic [63:0]     slot_first_sample [SLOTS];
  logic [63:0]     slot_time [SLOTS];
  logic            slot_gap [SLOTS];
  phase_t          phase;
  job_t            cur;
  logic [IdxW-1:0] free_rd, fifo_rd;
  logic [63:0]     seq_rd, first_rd, time_rd;
  logic            gap_rd;
  logic            stack_init;
  logic [CW-1:0]   init_ptr;
  logic [CW-1:0]   free_level;
  logic [AW-1:0]   fifo_head, fifo_tail;
  logic [CW-1:0]   fifo_count;
  logic [63:0]     next_sequence, cursor_pos, expected_sequence;
  logic            accepting;
  logic [CW-1:0]   fifo_peak_reg, slots_peak_reg;
  logic [63:0]     lost_bytes, drop_count;
  logic [CW-1:0]   cap;
  logic            go, do_admit, do_release;
  status_t         st;
  logic [CW-1:0]   top;
  logic [AW-1:0]   take_slot, pop_slot;
  logic [CW-1:0]   busy_next, cnt_next;

  assign job_ready = stack_init && (phase == S_IDLE) && (!res_valid || res_ready);
  assign go = job_valid && job_ready;
  assign do_admit = (phase == S_SLOT) && (cur.cmd == CMD_ADMIT) && (st == ST_ADMITTED);
  assign do_release = (phase == S_SLOT) && (cur.cmd == CMD_RELEASE) && cur.rel_ok &&
                      (free_level < CW'(SLOTS));

  always_comb begin
    cap = CW'(depth_limit);
    if (depth_limit == 7'd0) cap = CW'(1);
    if ({25'd0, depth_limit} > 32'(SLOTS)) cap = CW'(SLOTS);
  end

  always_comb begin
    st = ST_ADMITTED;
    if (!accepting) st = ST_STOPPED;
    else if (!cur.form_ok) st = ST_MALFORMED;
    else if (cur.len_short) st = ST_SHORT;
    else if (cur.len_over) st = ST_OVERSIZED;
    else if (free_level == '0) st = ST_POOL_EMPTY;
    else if (fifo_count >= cap) st = ST_FIFO_FULL;
    top = free_level - CW'(1);
    take_slot = AW'(free_rd);
    pop_slot = AW'(fifo_rd);
    busy_next = CW'(SLOTS) - top;
    cnt_next = fifo_count + CW'(1);
  end

  // stack fill sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_init <= 1'b0;
      init_ptr <= '0;
    end else if (!stack_init) begin
      init_ptr <= init_ptr + CW'(1);
      if (init_ptr == CW'(SLOTS - 1)) stack_init <= 1'b1;
    end
  end

  // stores: top of stack and head of ring read when a command starts,
  // metadata read in the following cycle for a pop
  always_ff @(posedge clk) begin
    if (!stack_init) begin
      free_stack[init_ptr[AW-1:0]] <= IdxW'(init_ptr);
    end else if (do_release) begin
      free_stack[free_level[AW-1:0]] <= cur.rel;
    end
    if (go) begin
      free_rd <= free_stack[top[AW-1:0]];
      fifo_rd <= ready_fifo[fifo_head];
    end
    if (do_admit) begin
      ready_fifo[fifo_tail] <= free_rd;
      slot_sequence[take_slot] <= next_sequence;
      slot_first_sample[take_slot] <= cursor_pos;
      slot_time[take_slot] <= cur.tbits;
      slot_gap[take_slot] <= next_sequence != expected_sequence;
    end
    if (phase == S_SLOT) begin
      seq_rd <= slot_sequence[pop_slot];
      first_rd <= slot_first_sample[pop_slot];
      time_rd <= slot_time[pop_slot];
      gap_rd <= slot_gap[pop_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= S_IDLE;
      res_valid <= 1'b0;
      free_level <= CW'(SLOTS);
      fifo_head <= '0;
      fifo_tail <= '0;
      fifo_count <= '0;
      next_sequence <= '0;
      cursor_pos <= '0;
      expected_sequence <= '0;
      accepting <= 1'b1;
      fifo_peak_reg <= '0;
      slots_peak_reg <= '0;
      lost_bytes <= '0;
      drop_count <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (phase)
        S_IDLE: begin
          if (go) begin
            cur <= job;
            phase <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (cur.cmd == CMD_POP && fifo_count != '0) begin
            phase <= S_META;
          end else begin
            phase <= S_IDLE;
            res_valid <= 1'b1;
            res.slot <= '0;
            res.seq <= '0;
            res.first <= '0;
            res.tout <= '0;
            res.gap <= 1'b0;
            res.fifo_level <= LvlW'(fifo_count);
            res.slots_busy <= LvlW'(CW'(SLOTS) - free_level);
            res.fifo_peak <= LvlW'(fifo_peak_reg);
            res.slots_peak <= LvlW'(slots_peak_reg);
            res.lost_bytes <= lost_bytes;
            res.loss_count <= drop_count;
            unique case (cur.cmd)
              CMD_ADMIT: begin
                res.status <= st;
                res.seq <= next_sequence;
                res.first <= cursor_pos;
                next_sequence <= next_sequence + 64'd1;
                cursor_pos <= cursor_pos + 64'(cur.len[LenW-1:1]);
                if (st != ST_ADMITTED) begin
                  lost_bytes <= lost_bytes + 64'(cur.len);
                  drop_count <= drop_count + 64'd1;
                  res.lost_bytes <= lost_bytes + 64'(cur.len);
                  res.loss_count <= drop_count + 64'd1;
                end else begin
                  free_level <= top;
                  expected_sequence <= next_sequence + 64'd1;
                  fifo_tail <= (fifo_tail == AW'(SLOTS - 1)) ? '0 : fifo_tail + AW'(1);
                  fifo_count <= cnt_next;
                  res.slot <= IdxW'(take_slot);
                  res.tout <= cur.tbits;
                  res.gap <= next_sequence != expected_sequence;
                  res.fifo_level <= LvlW'(cnt_next);
                  res.slots_busy <= LvlW'(busy_next);
                  if (cnt_next > fifo_peak_reg) begin
                    fifo_peak_reg <= cnt_next;
                    res.fifo_peak <= LvlW'(cnt_next);
                  end
                  if (busy_next > slots_peak_reg) begin
                    slots_peak_reg <= busy_next;
                    res.slots_peak <= LvlW'(busy_next);
                  end
                end
              end
              CMD_POP: begin
                res.status <= ST_EMPTY;
              end
              CMD_RELEASE: begin
                res.status <= ST_RELEASED;
                if (cur.rel_ok && free_level < CW'(SLOTS)) begin
                  free_level <= free_level + CW'(1);
                  res.slots_busy <= LvlW'(CW'(SLOTS) - free_level - CW'(1));
                end
              end
              default: begin
                res.status <= ST_STOP_DONE;
                accepting <= 1'b0;
              end
            endcase
          end
        end
        S_META: begin
          phase <= S_IDLE;
          res_valid <= 1'b1;
          res.status <= ST_POPPED;
          res.slot <= IdxW'(pop_slot);
          res.seq <= seq_rd;
          res.first <= first_rd;
          res.tout <= time_rd;
          res.gap <= gap_rd;
          res.fifo_level <= LvlW'(fifo_count - CW'(1));
          res.slots_busy <= LvlW'(CW'(SLOTS) - free_level);
          res.fifo_peak <= LvlW'(fifo_peak_reg);
          res.slots_peak <= LvlW'(slots_peak_reg);
          res.lost_bytes <= lost_bytes;
          res.loss_count <= drop_count;
          fifo_head <= (fifo_head == AW'(SLOTS - 1)) ? '0 : fifo_head + AW'(1);
          fifo_count <= fifo_count - CW'(1);
        end
        default: begin
          phase <= S_IDLE;
        end
      endcase
    end
  end
endmodule

/* design/block_buffer_admission_manager.sv */
// block buffer admission manager: front classifier, one-entry queue, back executor
// path: beat registered in the front, taken by the back in S_IDLE, result registered from
// S_SLOT (S_META for a pop that finds an entry); no new command is taken until back in S_IDLE
// back reads its slot stores through registers: slot number first, then pop metadata
// rst is synchronous, active high; after rst the free stack refills all SLOTS entries,
// the front holds at most one input beat until then (configuration writes still go through)
module block_buffer_admission_manager (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata: command[1:0], length_bytes[25:2], host_time_ns[89:26], release_index[95:90]
  input  logic [95:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata: status[3:0], slot_number[9:4], sequence_number[73:10], first_sample[137:74],
  // time_ns[201:138], gap_before[202], fifo_level[209:203], slots_busy[216:210],
  // fifo_peak[223:217], slots_peak[230:224], lost_bytes_total[294:231],
  // loss_count_total[358:295], zero fill
  output logic [359:0]  m_axis_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [23:0]   cfg_data
);
  import bbam_pkg::*;
  logic [23:0] block_bytes;
  logic [6:0]  depth_limit;
  logic        job_valid, job_ready;
  job_t        job;
  result_t     res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= 24'd262144;
      depth_limit <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLOCK_BYTES: block_bytes <= cfg_data;
        default: depth_limit <= cfg_data[6:0];
      endcase
    end
  end

  bbam_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(cmd_t'(s_axis_tdata[1:0])), .len(s_axis_tdata[25:2]),
    .tbits(s_axis_tdata[89:26]), .rel(s_axis_tdata[95:90]),
    .block_bytes, .job_valid, .job_ready, .job
  );

  bbam_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .depth_limit,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {1'b0, res.loss_count, res.lost_bytes, res.slots_peak,
                         res.fifo_peak, res.slots_busy, res.fifo_level, res.gap,
                         res.tout, res.first, res.seq, res.slot, res.status};
endmodule

/* design/bbam_checker.sv */
// port-level checker for the admission manager, with its bind
`include "assert_macros.svh"
module bbam_port_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [359:0] m_axis_tdata
);
  `CHK_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `CHK_IMPLY(a_status_range, clk, rst, m_axis_tvalid, m_axis_tdata[3:0] <= 4'd10, "status code out of range")
  `CHK_IMPLY(a_busy_peak, clk, rst, m_axis_tvalid, m_axis_tdata[216:210] <= m_axis_tdata[230:224], "busy slots above their peak")
  `CHK_IMPLY(a_peak, clk, rst, m_axis_tvalid, m_axis_tdata[209:203] <= m_axis_tdata[223:217], "fifo level above its peak")
endmodule

bind block_buffer_admission_manager bbam_port_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* bench/bbam_checker.sv */
// checker for the block buffer admission manager: watches the streams, predicts, compares
module bbam_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [359:0] m_axis_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_data,
  output int           errors,
  output int           pending
);
  import bbam_pkg::*;
  result_t     expected_results[$];

  logic [IdxW-1:0] free_slots[SLOTS];
  int              free_level;
  logic [IdxW-1:0] ready_queue[SLOTS];
  int              ring_head, ring_tail, ring_count;
  logic [63:0]     meta_seq[SLOTS], meta_first[SLOTS], meta_time[SLOTS];
  logic            meta_gap[SLOTS];
  logic [63:0]     next_seq, cursor, want_seq, lost_bytes, drop_count;
  bit              accepting;
  int              ring_peak, busy_peak;
  logic [23:0]     block_bytes;
  logic [6:0]      depth_limit;

  function automatic result_t admission_step(logic [95:0] d);
    cmd_t        c;
    logic [23:0] len;
    logic [63:0] t;
    logic [5:0]  rel;
    result_t     r;
    int          cap;
    c = cmd_t'(d[1:0]);
    len = d[25:2];
    t = d[89:26];
    rel = d[95:90];
    r = '0;
    case (c)
      CMD_ADMIT: begin
        r.seq = next_seq;
        next_seq = next_seq + 64'd1;
        r.first = cursor;
        cursor = cursor + 64'(len >> 1);
        cap = (depth_limit < 1) ? 1 : (depth_limit > SLOTS) ? SLOTS : depth_limit;
        if (!accepting) r.status = ST_STOPPED;
        else if (len == 0 || len[0] || t == 0 || t[63]) r.status = ST_MALFORMED;
        else if (len < block_bytes) r.status = ST_SHORT;
        else if (len > block_bytes) r.status = ST_OVERSIZED;
        else if (free_level == 0) r.status = ST_POOL_EMPTY;
        else if (ring_count >= cap) r.status = ST_FIFO_FULL;
        else r.status = ST_ADMITTED;
        if (r.status != ST_ADMITTED) begin
          lost_bytes = lost_bytes + 64'(len);
          drop_count = drop_count + 64'd1;
        end else begin
          free_level--;
          r.slot = free_slots[free_level];
          r.gap = (r.seq != want_seq);
          want_seq = r.seq + 64'd1;
          meta_seq[r.slot] = r.seq;
          meta_first[r.slot] = r.first;
          meta_time[r.slot] = t;
          meta_gap[r.slot] = r.gap;
          r.tout = t;
          ready_queue[ring_tail] = r.slot;
          ring_tail = (ring_tail + 1) % SLOTS;
          ring_count++;
          if (ring_count > ring_peak) ring_peak = ring_count;
          if (SLOTS - free_level > busy_peak) busy_peak = SLOTS - free_level;
        end
      end
      CMD_POP: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_POPPED;
          r.slot = ready_queue[ring_head];
          ring_head = (ring_head + 1) % SLOTS;
          ring_count--;
          r.seq = meta_seq[r.slot];
          r.first = meta_first[r.slot];
          r.tout = meta_time[r.slot];
          r.gap = meta_gap[r.slot];
        end
      end
      CMD_RELEASE: begin
        r.status = ST_RELEASED;
        if (rel < SLOTS && free_level < SLOTS) begin
          free_slots[free_level] = rel;
          free_level++;
        end
      end
      default: begin
        r.status = ST_STOP_DONE;
        accepting = 0;
      end
    endcase
    r.fifo_level = LvlW'(ring_count);
    r.slots_busy = LvlW'(SLOTS - free_level);
    r.fifo_peak = LvlW'(ring_peak);
    r.slots_peak = LvlW'(busy_peak);
    r.lost_bytes = lost_bytes;
    r.loss_count = drop_count;
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) free_slots[i] = IdxW'(i);
      free_level = SLOTS;
      ring_head = 0;
      ring_tail = 0;
      ring_count = 0;
      next_seq = 0;
      cursor = 0;
      want_seq = 0;
      lost_bytes = 0;
      drop_count = 0;
      accepting = 1;
      ring_peak = 0;
      busy_peak = 0;
      block_bytes = 24'd262144;
      depth_limit = 7'd64;
      expected_results.delete();
    end
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BLOCK_BYTES) block_bytes = cfg_data;
      else depth_limit = cfg_data[6:0];
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none, got %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        got.status     = status_t'(m_axis_tdata[3:0]);
        got.slot       = m_axis_tdata[9:4];
        got.seq        = m_axis_tdata[73:10];
        got.first      = m_axis_tdata[137:74];
        got.tout       = m_axis_tdata[201:138];
        got.gap        = m_axis_tdata[202];
        got.fifo_level = m_axis_tdata[209:203];
        got.slots_busy = m_axis_tdata[216:210];
        got.fifo_peak  = m_axis_tdata[223:217];
        got.slots_peak = m_axis_tdata[230:224];
        got.lost_bytes = m_axis_tdata[294:231];
        got.loss_count = m_axis_tdata[358:295];
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("slot_number", 64'(want.slot), 64'(got.slot));
        compare_field("sequence_number", want.seq, got.seq);
        compare_field("first_sample", want.first, got.first);
        compare_field("time_ns", want.tout, got.tout);
        compare_field("gap_before", 64'(want.gap), 64'(got.gap));
        compare_field("fifo_level", 64'(want.fifo_level), 64'(got.fifo_level));
        compare_field("slots_busy", 64'(want.slots_busy), 64'(got.slots_busy));
        compare_field("fifo_peak", 64'(want.fifo_peak), 64'(got.fifo_peak));
        compare_field("slots_peak", 64'(want.slots_peak), 64'(got.slots_peak));
        compare_field("lost_bytes_total", want.lost_bytes, got.lost_bytes);
        compare_field("loss_count_total", want.loss_count, got.loss_count);
        compare_field("zero fill", 64'd0, {63'd0, m_axis_tdata[359]});
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_results.push_back(admission_step(s_axis_tdata));
    pending = expected_results.size();
  end
endmodule

/* bench/testbench.sv */
// top of the admission manager bench: clock, reset, stimulus and verdict
module testbench;
  import bbam_pkg::*;

  logic          clk, rst;
  logic          s_axis_tvalid, s_axis_tready;
  logic [95:0]   s_axis_tdata;
  logic          m_axis_tvalid, m_axis_tready;
  logic [359:0]  m_axis_tdata;
  logic          cfg_valid, cfg_ready, cfg_index;
  logic [23:0]   cfg_data;
  int            errors, pending;
  int            cmds_taken, cfgs_taken, burst_left, stall_phase, quiet_cycles;
  logic [23:0]   cur_block;

  block_buffer_admission_manager DUT (.*);

  bbam_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) cmds_taken <= cmds_taken + 1;
    if (cfg_valid && cfg_ready) cfgs_taken <= cfgs_taken + 1;
  end

  // watchdog: cycles without any beat on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stall pattern: free running, random, then one in four
  always @(negedge clk) begin
    stall_phase = stall_phase + 1;
    case ((stall_phase / 97) % 3)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = 1'($urandom_range(0, 1));
      default: m_axis_tready = (stall_phase % 4) == 0;
    endcase
  end

  task automatic send_cmd(cmd_t c, logic [23:0] len, logic [63:0] t, logic [5:0] rel);
    int target;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tdata = {rel, t, len, c};
    s_axis_tvalid = 1'b1;
    target = cmds_taken + 1;
    do @(negedge clk); while (cmds_taken != target);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [23:0] value);
    int target;
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    target = cfgs_taken + 1;
    do @(negedge clk); while (cfgs_taken != target);
    cfg_valid = 1'b0;
    if (idx == CFG_BLOCK_BYTES) cur_block = value;
  endtask

  task automatic random_cmd(int admit_pct, int pop_pct);
    int          pick;
    logic [23:0] len;
    logic [63:0] t;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      6: len = 24'($urandom_range(0, 24'hFFFFFF));
      7: len = cur_block + 24'd2;
      8: len = cur_block - 24'd2;
      9: len = {23'($urandom_range(0, 24'h7FFFFF)), 1'b1};
      default: len = cur_block;
    endcase
    case ($urandom_range(0, 9))
      6: t = 64'd0;
      7: t = {1'b1, 31'($urandom), $urandom};
      8: t = 64'h7FFF_FFFF_FFFF_FFFF;
      9: t = {$urandom, $urandom};
      default: t = {1'b0, 31'($urandom), $urandom} | 64'd1;
    endcase
    if (pick < admit_pct) send_cmd(CMD_ADMIT, len, t, 6'd0);
    else if (pick < admit_pct + pop_pct) send_cmd(CMD_POP, len, t, 6'd0);
    else send_cmd(CMD_RELEASE, len, t, 6'($urandom_range(0, 63)));
  endtask

  task automatic random_phase(logic [23:0] blk, logic [6:0] depth, int count,
                              int admit_pct, int pop_pct);
    wait_idle();
    cfg_write(CFG_BLOCK_BYTES, blk);
    cfg_write(CFG_DEPTH_LIMIT, {17'd0, depth});
    repeat (count) random_cmd(admit_pct, pop_pct);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_BLOCK_BYTES;
    cfg_data = '0;
    cmds_taken = 0;
    cfgs_taken = 0;
    burst_left = 0;
    stall_phase = 0;
    quiet_cycles = 0;
    cur_block = 24'd262144;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: block of 4 bytes, two-entry ready queue
    cfg_write(CFG_BLOCK_BYTES, 24'd4);
    cfg_write(CFG_DEPTH_LIMIT, 24'd2);
    send_cmd(CMD_POP, 24'd0, 64'd0, 6'd0);
    send_cmd(CMD_ADMIT, 24'd4, 64'd1, 6'd0);
    send_cmd(CMD_ADMIT, 24'd0, 64'd5, 6'd0);
    send_cmd(CMD_ADMIT, 24'd3, 64'd5, 6'd0);
    send_cmd(CMD_ADMIT, 24'd4, 64'd0, 6'd0);
    send_cmd(CMD_ADMIT, 24'd4, 64'h8000_0000_0000_0000, 6'd0);
    send_cmd(CMD_ADMIT, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
    send_cmd(CMD_ADMIT, 24'd2, 64'd7, 6'd0);
    send_cmd(CMD_ADMIT, 24'd6, 64'd7, 6'd0);
    send_cmd(CMD_ADMIT, 24'd4, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
    send_cmd(CMD_ADMIT, 24'd4, 64'd9, 6'd0);
    send_cmd(CMD_POP, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'h3F);
    send_cmd(CMD_POP, 24'd0, 64'd0, 6'd0);
    send_cmd(CMD_POP, 24'd0, 64'd0, 6'd0);
    send_cmd(CMD_RELEASE, 24'd0, 64'd0, 6'd63);
    send_cmd(CMD_RELEASE, 24'd0, 64'd0, 6'd62);
    send_cmd(CMD_RELEASE, 24'd0, 64'd0, 6'd0);
    send_cmd(CMD_ADMIT, 24'd4, 64'd11, 6'd0);
    send_cmd(CMD_ADMIT, 24'd4, 64'd12, 6'd0);

    random_phase(24'd2, 7'd1, 100, 50, 40);
    // deep fill: pool and ready queue run out
    random_phase(24'd16777214, 7'd64, 150, 80, 5);
    random_phase(24'd0, 7'd0, 40, 60, 20);
    random_phase(24'd3, 7'd127, 40, 60, 20);
    random_phase({23'($urandom_range(1, 24'h7FFFFF)), 1'b0}, 7'($urandom_range(1, 64)),
                 200, 45, 35);
    random_phase(24'd8, 7'd8, 180, 50, 30);
    send_cmd(CMD_STOP, 24'd0, 64'd0, 6'd0);
    repeat (20) random_cmd(60, 20);

    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
